// ===== design/pr3d_pkg.sv =====
// Shared types, constants and trig helpers for the 3D point rotation pipeline.
`default_nettype none

package pr3d_pkg;

    localparam int TRIG_FRAC_BITS = 14;
    localparam int TAB_W          = TRIG_FRAC_BITS + 1;
    localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
    localparam int IN_W           = 8;
    localparam int COORD_W        = 9;
    localparam int ANGLE_W        = 9;
    localparam int PROD_W         = COORD_W + TRIG_W + 1;
    localparam int TAB_LAST       = 90;
    localparam int TAB_IDX_W      = 7;
    localparam int IN_TDATA_W     = 56;
    localparam int OUT_TDATA_W    = 32;

    localparam longint unsigned PI_Q30 = 64'd3373259426;

    localparam logic [ANGLE_W-1:0] DEG_90  = ANGLE_W'(90);
    localparam logic [ANGLE_W-1:0] DEG_180 = ANGLE_W'(180);
    localparam logic [ANGLE_W-1:0] DEG_270 = ANGLE_W'(270);
    localparam logic [ANGLE_W-1:0] DEG_360 = ANGLE_W'(360);

    localparam logic signed [TRIG_W-1:0]  TRIG_ONE  = TRIG_W'(64'd1 << TRIG_FRAC_BITS);
    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0]  SAT_HI    = PROD_W'(COORD_MAX);
    localparam logic signed [PROD_W-1:0]  SAT_LO    = PROD_W'(COORD_MIN);
    localparam logic signed [PROD_W-1:0]  TRUNC_BIAS =
        PROD_W'((64'd1 << TRIG_FRAC_BITS) - 64'd1);

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [TAB_W-1:0] sin_tab_t [0:TAB_LAST];

    typedef struct packed {
        logic signed [TRIG_W-1:0] s;
        logic signed [TRIG_W-1:0] c;
    } trig_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
        trig_t  tx;
        trig_t  ty;
        trig_t  tz;
    } stage_t;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } axis_t;

    // Quarter-wave sine in Q30 by truncated Taylor series, then rounded to the table format
    function automatic sin_tab_t build_sin_tab();
        sin_tab_t          tab;
        longint unsigned   x;
        longint unsigned   x2;
        longint unsigned   term;
        longint            acc;
        for (int d = 0; d <= TAB_LAST; d++)
        begin
            x    = (64'(d) * PI_Q30 + 64'd90) / 64'd180;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            // term k is divided by (2k)(2k+1), k = 1..8
            term = ((term * x2) >> 30) / 64'd6;
            acc  = acc - longint'(term);
            term = ((term * x2) >> 30) / 64'd20;
            acc  = acc + longint'(term);
            term = ((term * x2) >> 30) / 64'd42;
            acc  = acc - longint'(term);
            term = ((term * x2) >> 30) / 64'd72;
            acc  = acc + longint'(term);
            term = ((term * x2) >> 30) / 64'd110;
            acc  = acc - longint'(term);
            term = ((term * x2) >> 30) / 64'd156;
            acc  = acc + longint'(term);
            term = ((term * x2) >> 30) / 64'd210;
            acc  = acc - longint'(term);
            term = ((term * x2) >> 30) / 64'd272;
            acc  = acc + longint'(term);
            if (acc < 0)
                acc = 0;
            tab[d] = TAB_W'((acc + (longint'(1) << (29 - TRIG_FRAC_BITS)))
                            >>> (30 - TRIG_FRAC_BITS));
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_TAB = build_sin_tab();

    function automatic logic [ANGLE_W-1:0] wrap360(input logic [ANGLE_W-1:0] a);
        return (a >= DEG_360) ? a - DEG_360 : a;
    endfunction

    // a must already lie in 0..359
    function automatic logic signed [TRIG_W-1:0] sin_lookup(input logic [ANGLE_W-1:0] a);
        logic [ANGLE_W-1:0]       m;
        logic                     neg;
        logic signed [TRIG_W-1:0] mag;
        if (a <= DEG_90)
        begin
            m   = a;
            neg = 1'b0;
        end
        else if (a <= DEG_180)
        begin
            m   = DEG_180 - a;
            neg = 1'b0;
        end
        else if (a <= DEG_270)
        begin
            m   = a - DEG_180;
            neg = 1'b1;
        end
        else
        begin
            m   = DEG_360 - a;
            neg = 1'b1;
        end
        mag = TRIG_W'(SIN_TAB[m[TAB_IDX_W-1:0]]);
        return neg ? -mag : mag;
    endfunction

    // divide by 2^F, rounding toward zero
    function automatic logic signed [PROD_W-1:0] scale_down(input logic signed [PROD_W-1:0] v);
        return (v < 0) ? ((v + TRUNC_BIAS) >>> TRIG_FRAC_BITS) : (v >>> TRIG_FRAC_BITS);
    endfunction

    function automatic coord_t sat_coord(input logic signed [PROD_W-1:0] v);
        if (v > SAT_HI)
            return COORD_MAX;
        else if (v < SAT_LO)
            return COORD_MIN;
        else
            return v[COORD_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/point_rotation_3d_top.sv =====
// Top level: 3D point rotation about X, then Y, then Z, as a four-stage stream pipeline.
// Each point passes the lookup, X, Y and Z registers in that order.
// Throughput: one point per cycle unless the output stalls; each stage has its own
// valid bit and ready, so a stalled output only holds the stages that are full.
// Each rotation stage is one register after four 9x16 multipliers, a subtract and an add.
// Reset clears the valid bits only; payload registers are not reset.
`default_nettype none

module point_rotation_3d_top (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // in_x, in_y, in_z, angle_x_deg, angle_y_deg, angle_z_deg, zero pad
    input  wire logic [pr3d_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // out_x, out_y, out_z, zero pad
    output logic [pr3d_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);

    logic              trig_valid;
    logic              trig_ready;
    pr3d_pkg::stage_t  trig_data;
    logic              rx_valid;
    logic              rx_ready;
    pr3d_pkg::stage_t  rx_data;
    logic              ry_valid;
    logic              ry_ready;
    pr3d_pkg::stage_t  ry_data;
    pr3d_pkg::stage_t  rz_data;

    pr3d_trig u_trig (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_x        (s_axis_tdata[7:0]),
        .in_y        (s_axis_tdata[15:8]),
        .in_z        (s_axis_tdata[23:16]),
        .angle_x_deg (s_axis_tdata[32:24]),
        .angle_y_deg (s_axis_tdata[41:33]),
        .angle_z_deg (s_axis_tdata[50:42]),
        .out_valid   (trig_valid),
        .out_ready   (trig_ready),
        .out_data    (trig_data)
    );

    pr3d_rotate u_rot_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .axis      (pr3d_pkg::AXIS_X),
        .in_valid  (trig_valid),
        .in_ready  (trig_ready),
        .in_data   (trig_data),
        .out_valid (rx_valid),
        .out_ready (rx_ready),
        .out_data  (rx_data)
    );

    pr3d_rotate u_rot_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .axis      (pr3d_pkg::AXIS_Y),
        .in_valid  (rx_valid),
        .in_ready  (rx_ready),
        .in_data   (rx_data),
        .out_valid (ry_valid),
        .out_ready (ry_ready),
        .out_data  (ry_data)
    );

    pr3d_rotate u_rot_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .axis      (pr3d_pkg::AXIS_Z),
        .in_valid  (ry_valid),
        .in_ready  (ry_ready),
        .in_data   (ry_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (rz_data)
    );

    assign m_axis_tdata = {5'b0, rz_data.z, rz_data.y, rz_data.x};

endmodule

`default_nettype wire

// ===== design/pr3d_trig.sv =====
// Front stage: angle wrap and sine/cosine table lookup for all three axes.
`default_nettype none

module pr3d_trig (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [pr3d_pkg::IN_W-1:0]    in_x,
    input  wire logic signed [pr3d_pkg::IN_W-1:0]    in_y,
    input  wire logic signed [pr3d_pkg::IN_W-1:0]    in_z,
    input  wire logic [pr3d_pkg::ANGLE_W-1:0]        angle_x_deg,
    input  wire logic [pr3d_pkg::ANGLE_W-1:0]        angle_y_deg,
    input  wire logic [pr3d_pkg::ANGLE_W-1:0]        angle_z_deg,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output pr3d_pkg::stage_t                   out_data
);

    logic              valid_reg;
    pr3d_pkg::stage_t  data_reg;
    pr3d_pkg::stage_t  data_next;
    logic [pr3d_pkg::ANGLE_W-1:0] ax;
    logic [pr3d_pkg::ANGLE_W-1:0] ay;
    logic [pr3d_pkg::ANGLE_W-1:0] az;

    always_comb
    begin
        ax = pr3d_pkg::wrap360(angle_x_deg);
        ay = pr3d_pkg::wrap360(angle_y_deg);
        az = pr3d_pkg::wrap360(angle_z_deg);
        data_next.x    = pr3d_pkg::COORD_W'(in_x);
        data_next.y    = pr3d_pkg::COORD_W'(in_y);
        data_next.z    = pr3d_pkg::COORD_W'(in_z);
        data_next.tx.s = pr3d_pkg::sin_lookup(ax);
        data_next.tx.c = pr3d_pkg::sin_lookup(pr3d_pkg::wrap360(ax + pr3d_pkg::DEG_90));
        data_next.ty.s = pr3d_pkg::sin_lookup(ay);
        data_next.ty.c = pr3d_pkg::sin_lookup(pr3d_pkg::wrap360(ay + pr3d_pkg::DEG_90));
        data_next.tz.s = pr3d_pkg::sin_lookup(az);
        data_next.tz.c = pr3d_pkg::sin_lookup(pr3d_pkg::wrap360(az + pr3d_pkg::DEG_90));
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

`ifndef SYNTHESIS
    a_zero_angle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && angle_x_deg == '0
        |=> data_reg.tx.s == '0 && data_reg.tx.c == pr3d_pkg::TRIG_ONE)
        else $error("zero angle did not give sin 0, cos 1");

    a_trig_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> data_reg.ty.s <= pr3d_pkg::TRIG_ONE && data_reg.ty.s >= -pr3d_pkg::TRIG_ONE
                   && data_reg.ty.c <= pr3d_pkg::TRIG_ONE && data_reg.ty.c >= -pr3d_pkg::TRIG_ONE)
        else $error("trig value beyond unit magnitude");
`endif

endmodule

`default_nettype wire

// ===== design/pr3d_rotate.sv =====
// One rotation stage: two sums of products, truncation toward zero, clamp, register.
`default_nettype none

module pr3d_rotate (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire pr3d_pkg::axis_t      axis,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire pr3d_pkg::stage_t     in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output pr3d_pkg::stage_t          out_data
);

    logic              valid_reg;
    pr3d_pkg::stage_t  data_reg;
    pr3d_pkg::stage_t  data_next;
    pr3d_pkg::coord_t  a;
    pr3d_pkg::coord_t  b;
    pr3d_pkg::coord_t  na;
    pr3d_pkg::coord_t  nb;
    pr3d_pkg::trig_t   t;
    logic signed [pr3d_pkg::PROD_W-1:0] prod_ac;
    logic signed [pr3d_pkg::PROD_W-1:0] prod_bs;
    logic signed [pr3d_pkg::PROD_W-1:0] prod_as;
    logic signed [pr3d_pkg::PROD_W-1:0] prod_bc;

    // a' = a*c - b*s, b' = a*s + b*c with (a,b) = (y,z), (z,x) or (x,y)
    always_comb
    begin
        case (axis)
            pr3d_pkg::AXIS_X:
            begin
                a = in_data.y;
                b = in_data.z;
                t = in_data.tx;
            end
            pr3d_pkg::AXIS_Y:
            begin
                a = in_data.z;
                b = in_data.x;
                t = in_data.ty;
            end
            default:
            begin
                a = in_data.x;
                b = in_data.y;
                t = in_data.tz;
            end
        endcase

        prod_ac = pr3d_pkg::PROD_W'(a) * pr3d_pkg::PROD_W'($signed(t.c));
        prod_bs = pr3d_pkg::PROD_W'(b) * pr3d_pkg::PROD_W'($signed(t.s));
        prod_as = pr3d_pkg::PROD_W'(a) * pr3d_pkg::PROD_W'($signed(t.s));
        prod_bc = pr3d_pkg::PROD_W'(b) * pr3d_pkg::PROD_W'($signed(t.c));

        na = pr3d_pkg::sat_coord(pr3d_pkg::scale_down(prod_ac - prod_bs));
        nb = pr3d_pkg::sat_coord(pr3d_pkg::scale_down(prod_as + prod_bc));

        data_next = in_data;
        case (axis)
            pr3d_pkg::AXIS_X:
            begin
                data_next.y = na;
                data_next.z = nb;
            end
            pr3d_pkg::AXIS_Y:
            begin
                data_next.z = na;
                data_next.x = nb;
            end
            default:
            begin
                data_next.x = na;
                data_next.y = nb;
            end
        endcase
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            data_reg <= data_next;
    end

`ifndef SYNTHESIS
    a_identity: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && t.s == '0 && t.c == pr3d_pkg::TRIG_ONE
        |=> data_reg.x == $past(in_data.x) && data_reg.y == $past(in_data.y)
            && data_reg.z == $past(in_data.z))
        else $error("zero rotation changed the point");

    a_axis_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready
        |=> ($past(axis) == pr3d_pkg::AXIS_X) ? data_reg.x == $past(in_data.x) :
            ($past(axis) == pr3d_pkg::AXIS_Y) ? data_reg.y == $past(in_data.y) :
                                                data_reg.z == $past(in_data.z))
        else $error("coordinate on the rotation axis was altered");
`endif

endmodule

`default_nettype wire

// ===== verif/point_rotation_3d_top_tb.sv =====
// Self-checking stream testbench for the 3D point rotation pipeline.
module point_rotation_3d_top_tb;

    typedef pr3d_pkg::coord_t coord_t;

    localparam int IN_TDATA_W       = pr3d_pkg::IN_TDATA_W;
    localparam int OUT_TDATA_W      = pr3d_pkg::OUT_TDATA_W;
    localparam int FRAC             = pr3d_pkg::TRIG_FRAC_BITS;
    localparam longint unsigned PI_Q30_L = 64'd3373259426;
    localparam longint TRIG_UNIT    = longint'(1) << FRAC;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int SINK_HOLD_CYCLES = 150;
    localparam int BURST_ITEMS      = 40;
    localparam int RANDOM_ITEMS     = 540;
    localparam int TAIL_ITEMS       = 100;

    typedef struct {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    class rotation_scoreboard;
        longint sine_q [0:90];
        point_t rotated_q [$];
        int     failures;

        function new();
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint          acc;
            failures = 0;
            // quarter-wave sine in Q30 by truncated series, rounded to the table format
            for (int d = 0; d <= 90; d++)
            begin
                x    = (longint'(d) * PI_Q30_L + 64'd90) / 64'd180;
                x2   = (x * x) >> 30;
                term = x;
                acc  = longint'(x);
                for (int k = 1; k <= 8; k++)
                begin
                    term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
                    if (k % 2 == 1)
                        acc = acc - longint'(term);
                    else
                        acc = acc + longint'(term);
                end
                if (acc < 0)
                    acc = 0;
                sine_q[d] = longint'((longint'(acc) + (longint'(1) << (29 - FRAC)))
                                     >> (30 - FRAC));
            end
        endfunction

        function longint sin_of(int unsigned a);
            int unsigned m;
            m = a % 360;
            if (m <= 90)
                return sine_q[m];
            else if (m <= 180)
                return sine_q[180 - m];
            else if (m <= 270)
                return -sine_q[m - 180];
            return -sine_q[360 - m];
        endfunction

        function longint cos_of(int unsigned a);
            return sin_of(a % 360 + 90);
        endfunction

        function coord_t clamp(longint v);
            if (v > 255)
                return coord_t'(255);
            if (v < -256)
                return coord_t'(-256);
            return coord_t'(v);
        endfunction

        // X, then Y, then Z; each stage truncates toward zero
        function point_t rotate_xyz(logic [IN_TDATA_W-1:0] req);
            longint x;
            longint y;
            longint z;
            longint s;
            longint c;
            longint nx;
            longint ny;
            longint nz;
            point_t p;
            x = longint'($signed(req[7:0]));
            y = longint'($signed(req[15:8]));
            z = longint'($signed(req[23:16]));
            s = sin_of(req[32:24]);
            c = cos_of(req[32:24]);
            ny = (y * c - z * s) / TRIG_UNIT;
            nz = (y * s + z * c) / TRIG_UNIT;
            y = ny;
            z = nz;
            s = sin_of(req[41:33]);
            c = cos_of(req[41:33]);
            nx = (x * c + z * s) / TRIG_UNIT;
            nz = (z * c - x * s) / TRIG_UNIT;
            x = nx;
            z = nz;
            s = sin_of(req[50:42]);
            c = cos_of(req[50:42]);
            nx = (x * c - y * s) / TRIG_UNIT;
            ny = (x * s + y * c) / TRIG_UNIT;
            p.x = clamp(nx);
            p.y = clamp(ny);
            p.z = clamp(z);
            return p;
        endfunction

        function void note_request(logic [IN_TDATA_W-1:0] req);
            rotated_q.push_back(rotate_xyz(req));
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] res);
            point_t want;
            coord_t got_x;
            coord_t got_y;
            coord_t got_z;
            got_x = res[8:0];
            got_y = res[17:9];
            got_z = res[26:18];
            if (rotated_q.size() == 0)
            begin
                failures++;
                if (failures <= 30)
                    $error("result with no request pending: x %0d y %0d z %0d",
                           got_x, got_y, got_z);
                return;
            end
            want = rotated_q.pop_front();
            if (got_x !== want.x)
            begin
                failures++;
                if (failures <= 30)
                    $error("out_x: expected %0d, got %0d", want.x, got_x);
            end
            if (got_y !== want.y)
            begin
                failures++;
                if (failures <= 30)
                    $error("out_y: expected %0d, got %0d", want.y, got_y);
            end
            if (got_z !== want.z)
            begin
                failures++;
                if (failures <= 30)
                    $error("out_z: expected %0d, got %0d", want.z, got_z);
            end
        endfunction

        function int pending();
            return rotated_q.size();
        endfunction
    endclass

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tready;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    bit hold_sink = 1'b0;
    bit no_idle   = 1'b0;
    int stall_cycles = 0;

    rotation_scoreboard rot_sb = new();

    point_rotation_3d_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    function automatic logic [IN_TDATA_W-1:0] pack_request(
        input logic [7:0] x, input logic [7:0] y, input logic [7:0] z,
        input logic [8:0] ax, input logic [8:0] ay, input logic [8:0] az);
        return {5'b0, az, ay, ax, z, y, x};
    endfunction

    // mostly in-range angles, now and then the full 9-bit field
    function automatic logic [8:0] random_angle();
        if ($urandom_range(0, 7) == 0)
            return 9'($urandom_range(0, 511));
        return 9'($urandom_range(0, 359));
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_request();
        return pack_request(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), random_angle(), random_angle(),
                            random_angle());
    endfunction

    // called at a rising edge; returns at the edge that takes the request, or after a random idle gap behind it
    task automatic send_point(input logic [IN_TDATA_W-1:0] req, input bit allow_idle);
        s_axis_tdata  <= req;
        s_axis_tvalid <= 1'b1;
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        rot_sb.note_request(req);
        @(posedge clk);
        if (allow_idle && !no_idle && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= IN_TDATA_W'({$urandom, $urandom});
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // sink side: random stalls, one long hold on demand, none in the tail
    initial
    begin
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
                hold_sink = 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // sampled mid-cycle: the handshake completes at the next rising edge
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            rot_sb.check_result(m_axis_tdata);
    end

    always @(negedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("point_rotation_3d_top_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // field extremes, every quadrant edge on each axis, angles past 359
        send_point(pack_request(8'sd0, 8'sd0, 8'sd0, 9'd0, 9'd0, 9'd0), 1'b1);
        send_point(pack_request(8'sd127, 8'sd127, 8'sd127, 9'd0, 9'd0, 9'd0), 1'b1);
        send_point(pack_request(-8'sd128, -8'sd128, -8'sd128, 9'd0, 9'd0, 9'd0), 1'b1);
        send_point(pack_request(8'sd127, -8'sd128, 8'sd0, 9'd90, 9'd0, 9'd0), 1'b1);
        send_point(pack_request(8'sd127, -8'sd128, 8'sd100, 9'd180, 9'd0, 9'd0), 1'b1);
        send_point(pack_request(-8'sd128, 8'sd127, -8'sd1, 9'd270, 9'd0, 9'd0), 1'b1);
        send_point(pack_request(-8'sd1, 8'sd1, 8'sd127, 9'd359, 9'd0, 9'd0), 1'b1);
        send_point(pack_request(8'sd100, -8'sd50, 8'sd127, 9'd0, 9'd90, 9'd0), 1'b1);
        send_point(pack_request(-8'sd128, 8'sd0, 8'sd127, 9'd0, 9'd180, 9'd0), 1'b1);
        send_point(pack_request(8'sd127, 8'sd127, -8'sd128, 9'd0, 9'd270, 9'd0), 1'b1);
        send_point(pack_request(-8'sd128, -8'sd128, 8'sd127, 9'd0, 9'd359, 9'd0), 1'b1);
        send_point(pack_request(8'sd127, 8'sd0, -8'sd128, 9'd0, 9'd0, 9'd90), 1'b1);
        send_point(pack_request(-8'sd128, 8'sd127, 8'sd0, 9'd0, 9'd0, 9'd180), 1'b1);
        send_point(pack_request(8'sd127, -8'sd128, -8'sd128, 9'd0, 9'd0, 9'd270), 1'b1);
        send_point(pack_request(8'sd1, -8'sd1, 8'sd1, 9'd0, 9'd0, 9'd359), 1'b1);
        send_point(pack_request(8'sd127, 8'sd127, 8'sd127, 9'd45, 9'd45, 9'd45), 1'b1);
        send_point(pack_request(-8'sd128, -8'sd128, -8'sd128, 9'd135, 9'd225, 9'd315),
                   1'b1);
        send_point(pack_request(8'sd50, 8'sd60, 8'sd70, 9'd360, 9'd360, 9'd360), 1'b1);
        send_point(pack_request(8'sd127, -8'sd128, 8'sd127, 9'd511, 9'd511, 9'd511), 1'b1);
        send_point(pack_request(-8'sd128, 8'sd127, -8'sd128, 9'd450, 9'd400, 9'd480), 1'b1);
        send_point(pack_request(8'sd127, 8'sd127, -8'sd128, 9'd91, 9'd179, 9'd181), 1'b1);
        send_point(pack_request(-8'sd128, 8'sd127, 8'sd127, 9'd89, 9'd1, 9'd269), 1'b1);

        // sink holds off while requests keep coming, so the pipe fills and backs up
        hold_sink = 1'b1;
        repeat (BURST_ITEMS) send_point(random_request(), 1'b0);

        // source pauses until every result is out
        s_axis_tvalid <= 1'b0;
        while (hold_sink)
            @(posedge clk);
        do
            @(posedge clk);
        while (rot_sb.pending() != 0);

        repeat (RANDOM_ITEMS) send_point(random_request(), 1'b1);
        no_idle = 1'b1;
        repeat (TAIL_ITEMS) send_point(random_request(), 1'b0);

        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (rot_sb.pending() != 0);
        repeat (8) @(posedge clk);

        if (rot_sb.failures == 0 && rot_sb.pending() == 0)
            $display("point_rotation_3d_top_tb OK");
        else
            $display("point_rotation_3d_top_tb NOT OK");
        $finish;
    end

endmodule
